@@ rtl/core/lzw_compressor_14bit_assert.svh @@
// Assertion macros for the LZW compressor controller.
`ifndef LZW_COMPRESSOR_14BIT_ASSERT_SVH
`define LZW_COMPRESSOR_14BIT_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define LZWC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lzwc assertion failed");

// Next-cycle implication, checked on aclk outside reset.
`define LZWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lzwc assertion failed");

`endif

@@ rtl/core/lzwc_pkg.sv @@
// Shared constants, types and hash functions of the LZW compressor.
package lzwc_pkg;

    localparam int CODE_BITS    = 14;
    localparam int HASH_ENTRIES = 18041;
    localparam int IDX_W        = $clog2(HASH_ENTRIES);
    localparam int END_CODE     = (1 << CODE_BITS) - 1;
    localparam int LAST_CODE    = END_CODE - 1;
    localparam int FIRST_FREE   = 256;
    localparam int LEN_W        = 24;
    localparam int EPOCH_W      = 8;
    localparam int PEND_W       = 7;
    localparam int PCNT_W       = 3;
    localparam int ACC_W        = CODE_BITS + PEND_W;
    localparam int TOT_W        = $clog2(ACC_W + 1);
    localparam int HOME_W       = (CODE_BITS > IDX_W) ? CODE_BITS : IDX_W;
    localparam int HOME_SUBS    = ((1 << CODE_BITS) - 1) / HASH_ENTRIES;

    // Which code the packer takes next
    localparam logic [1:0] TAIL_MISS = 2'd0;  // string code on a dictionary miss
    localparam logic [1:0] TAIL_CUR  = 2'd1;  // final string code at block end
    localparam logic [1:0] TAIL_END  = 2'd2;  // end code
    localparam logic [1:0] TAIL_ZERO = 2'd3;  // zero flush code

    typedef struct packed {
        logic [EPOCH_W-1:0]   epoch;
        logic [CODE_BITS-1:0] code;
        logic [CODE_BITS-1:0] prefix;
        logic [7:0]           chr;
    } dict_entry_t;

    typedef struct packed {
        logic       accept;
        logic       rd;
        logic       insert;
        logic       hit;
        logic       advance;
        logic       load;
        logic [1:0] tail;
        logic       emit;
        logic       pack_done;
        logic       finish;
        logic       too_big;
        logic       clear_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic first_seen;
        logic final_now;
        logic final_blk;
        logic slot_empty;
        logic slot_match;
        logic probe_last;
        logic dropped;
        logic total_ge8;
        logic hold_valid;
        logic out_free;
        logic epoch_max;
        logic clear_last;
    } dp_status_t;

    // Home slot: (chr << (CODE_BITS-8)) xor prefix, reduced into the table
    function automatic logic [IDX_W-1:0] home_slot(input logic [CODE_BITS-1:0] prefix,
                                                   input logic [7:0] chr);
        logic [HOME_W-1:0] x;
        x = HOME_W'({chr, {(CODE_BITS-8){1'b0}}} ^ prefix);
        for (int i = 0; i < HOME_SUBS; i++) begin
            if (x >= HOME_W'(HASH_ENTRIES)) begin
                x = x - HOME_W'(HASH_ENTRIES);
            end
        end
        return IDX_W'(x);
    endfunction

    // Secondary probe: step back by (entries - idx), or by 1 from slot zero
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] step;
        logic [IDX_W:0]   sum;
        step = (idx == '0) ? IDX_W'(1) : IDX_W'(HASH_ENTRIES) - idx;
        sum  = {1'b0, idx} + (IDX_W+1)'(HASH_ENTRIES) - {1'b0, step};
        if (idx >= step) begin
            return idx - step;
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/core/lzwc_ram.sv @@
// Generic simple dual-port RAM with registered read.
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/lzwc_datapath.sv @@
// Datapath: dictionary table, block counters, bit packer and output register.
module lzwc_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lzwc_pkg::ctrl_cmd_t      cmd,
    output lzwc_pkg::dp_status_t     st,
    input  logic [7:0]               s_data_byte,
    input  logic                     cfg_wen,
    input  logic [lzwc_pkg::LEN_W-1:0] cfg_wdata,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_out_byte,
    output logic                     m_has_byte,
    output logic                     m_out_last,
    output logic                     m_too_big
);

    localparam int CB = lzwc_pkg::CODE_BITS;
    localparam int IW = lzwc_pkg::IDX_W;
    localparam int LW = lzwc_pkg::LEN_W;

    logic [LW-1:0]               blen_reg;
    logic [LW-1:0]               in_cnt_reg;
    logic [LW-1:0]               out_cnt_reg;
    logic                        first_seen_reg;
    logic                        final_reg;
    logic [7:0]                  chr_reg;
    logic [CB-1:0]               cur_reg;
    logic [CB-1:0]               nfc_reg;
    logic [IW-1:0]               idx_reg;
    logic [IW-1:0]               probe_cnt_reg;
    logic [IW-1:0]               clr_cnt_reg;
    logic [lzwc_pkg::EPOCH_W-1:0] epoch_reg;
    logic [lzwc_pkg::ACC_W-1:0]  acc_reg;
    logic [lzwc_pkg::TOT_W-1:0]  tot_reg;
    logic [lzwc_pkg::PEND_W-1:0] pend_reg;
    logic [lzwc_pkg::PCNT_W-1:0] pcnt_reg;
    logic                        hold_valid_reg;
    logic [7:0]                  hold_byte_reg;
    logic                        out_valid_reg;
    logic [7:0]                  out_byte_reg;
    logic                        out_has_reg;
    logic                        out_last_reg;
    logic                        out_big_reg;

    logic [LW-1:0]               len;
    logic [LW-1:0]               limit;
    logic [LW-1:0]               in_cnt_inc;
    logic                        dict_full;
    logic [CB-1:0]               code_sel;
    logic [lzwc_pkg::ACC_W-1:0]  shifted;
    logic [7:0]                  pack_byte;
    logic                        out_free;
    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    lzwc_pkg::dict_entry_t       ram_wentry;
    logic [$bits(lzwc_pkg::dict_entry_t)-1:0] ram_rword;
    lzwc_pkg::dict_entry_t       rd_entry;
    logic                        slot_valid;

    // block length and output limit
    assign len        = (blen_reg == '0) ? LW'(1) : blen_reg;
    assign limit      = len - LW'(1);
    assign in_cnt_inc = in_cnt_reg + LW'(1);
    assign dict_full  = nfc_reg > CB'(lzwc_pkg::LAST_CODE);

    // dictionary table
    assign ram_we     = cmd.clear_step | (cmd.insert & ~dict_full);
    assign ram_waddr  = cmd.clear_step ? clr_cnt_reg : idx_reg;
    assign ram_wentry = cmd.clear_step ? lzwc_pkg::dict_entry_t'('0)
                                       : lzwc_pkg::dict_entry_t'{epoch: epoch_reg,
                                                                 code: nfc_reg,
                                                                 prefix: cur_reg,
                                                                 chr: chr_reg};

    lzwc_ram #(
        .WIDTH ($bits(lzwc_pkg::dict_entry_t)),
        .DEPTH (lzwc_pkg::HASH_ENTRIES)
    ) u_dict (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (ram_rword)
    );

    assign rd_entry   = ram_rword;
    assign slot_valid = rd_entry.epoch == epoch_reg;

    // packer code select and byte extraction
    always_comb begin
        unique case (cmd.tail)
            lzwc_pkg::TAIL_END:  code_sel = CB'(lzwc_pkg::END_CODE);
            lzwc_pkg::TAIL_ZERO: code_sel = '0;
            default:             code_sel = cur_reg;
        endcase
    end

    assign shifted   = acc_reg >> (tot_reg - lzwc_pkg::TOT_W'(8));
    assign pack_byte = shifted[7:0];
    assign out_free  = ~out_valid_reg | m_ready;

    // status to the controller
    assign st.first_seen = first_seen_reg;
    assign st.final_now  = in_cnt_inc >= len;
    assign st.final_blk  = final_reg;
    assign st.slot_empty = ~slot_valid;
    assign st.slot_match = slot_valid && rd_entry.prefix == cur_reg && rd_entry.chr == chr_reg;
    assign st.probe_last = probe_cnt_reg == IW'(lzwc_pkg::HASH_ENTRIES - 1);
    assign st.dropped    = out_cnt_reg >= limit;
    assign st.total_ge8  = tot_reg >= lzwc_pkg::TOT_W'(8);
    assign st.hold_valid = hold_valid_reg;
    assign st.out_free   = out_free;
    assign st.epoch_max  = epoch_reg == '1;
    assign st.clear_last = clr_cnt_reg == IW'(lzwc_pkg::HASH_ENTRIES - 1);

    // control state: config, counters, epoch, clear sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blen_reg       <= LW'(1);
            in_cnt_reg     <= '0;
            first_seen_reg <= 1'b0;
            epoch_reg      <= lzwc_pkg::EPOCH_W'(1);
            clr_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen) begin
                blen_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                in_cnt_reg     <= st.final_now ? '0 : in_cnt_inc;
                first_seen_reg <= 1'b1;
            end
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            end
            if (cmd.emit && final_reg) begin
                hold_valid_reg <= 1'b1;
            end
            if (cmd.finish) begin
                first_seen_reg <= 1'b0;
                hold_valid_reg <= 1'b0;
                if (epoch_reg == '1) begin
                    epoch_reg   <= lzwc_pkg::EPOCH_W'(1);
                    clr_cnt_reg <= '0;
                end else begin
                    epoch_reg <= epoch_reg + lzwc_pkg::EPOCH_W'(1);
                end
            end
        end
    end

    // string, dictionary and packer payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            chr_reg       <= s_data_byte;
            final_reg     <= st.final_now;
            idx_reg       <= lzwc_pkg::home_slot(cur_reg, s_data_byte);
            probe_cnt_reg <= '0;
            if (!first_seen_reg) begin
                cur_reg     <= CB'(s_data_byte);
                nfc_reg     <= CB'(lzwc_pkg::FIRST_FREE);
                pend_reg    <= '0;
                pcnt_reg    <= '0;
                out_cnt_reg <= '0;
            end
        end
        if (cmd.advance) begin
            idx_reg       <= lzwc_pkg::next_slot(idx_reg);
            probe_cnt_reg <= probe_cnt_reg + IW'(1);
        end
        if (cmd.insert && !dict_full) begin
            nfc_reg <= nfc_reg + CB'(1);
        end
        if (cmd.hit) begin
            cur_reg <= rd_entry.code;
        end
        if (cmd.load) begin
            if (cmd.tail == lzwc_pkg::TAIL_MISS) begin
                cur_reg <= CB'(chr_reg);
            end
            if (!st.dropped) begin
                acc_reg <= {pend_reg, code_sel};
                tot_reg <= lzwc_pkg::TOT_W'(pcnt_reg) + lzwc_pkg::TOT_W'(CB);
            end
        end
        if (cmd.emit) begin
            tot_reg     <= tot_reg - lzwc_pkg::TOT_W'(8);
            out_cnt_reg <= out_cnt_reg + LW'(1);
            if (final_reg) begin
                hold_byte_reg <= pack_byte;
            end
        end
        if (cmd.pack_done) begin
            pend_reg <= acc_reg[lzwc_pkg::PEND_W-1:0]
                      & ((lzwc_pkg::PEND_W'(1) << tot_reg[lzwc_pkg::PCNT_W-1:0])
                         - lzwc_pkg::PEND_W'(1));
            pcnt_reg <= tot_reg[lzwc_pkg::PCNT_W-1:0];
        end
    end

    // output register: direct bytes, held bytes and the closing transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
            out_byte_reg  <= hold_valid_reg ? hold_byte_reg : 8'd0;
            out_has_reg   <= hold_valid_reg;
            out_last_reg  <= 1'b1;
            out_big_reg   <= cmd.too_big;
        end else if (cmd.emit && (!final_reg || hold_valid_reg)) begin
            out_valid_reg <= 1'b1;
            out_byte_reg  <= final_reg ? hold_byte_reg : pack_byte;
            out_has_reg   <= 1'b1;
            out_last_reg  <= 1'b0;
            out_big_reg   <= 1'b0;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_has_byte = out_has_reg;
    assign m_out_last = out_last_reg;
    assign m_too_big  = out_big_reg;

endmodule

@@ rtl/core/lzwc_ctrl.sv @@
// Controller: sequences table probes, code packing and block end.
`include "lzw_compressor_14bit_assert.svh"

module lzwc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lzwc_pkg::dp_status_t st,
    output lzwc_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;
    localparam logic [2:0] S_BYTE  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] tail_reg;
    logic [1:0] tail_next;
    logic       big_reg;
    logic       big_next;
    logic [2:0] adv_state;
    logic [1:0] adv_tail;
    logic       emit_ok;

    // where to go once the current code is packed or dropped
    always_comb begin
        unique case (tail_reg)
            lzwc_pkg::TAIL_MISS: begin
                adv_state = st.final_blk ? S_LOAD : S_IDLE;
                adv_tail  = lzwc_pkg::TAIL_CUR;
            end
            lzwc_pkg::TAIL_CUR: begin
                adv_state = S_LOAD;
                adv_tail  = lzwc_pkg::TAIL_END;
            end
            lzwc_pkg::TAIL_END: begin
                adv_state = S_LOAD;
                adv_tail  = lzwc_pkg::TAIL_ZERO;
            end
            default: begin
                adv_state = S_DONE;
                adv_tail  = lzwc_pkg::TAIL_ZERO;
            end
        endcase
    end

    // final-step bytes pass through the hold stage first
    assign emit_ok = st.final_blk ? (~st.hold_valid | st.out_free) : st.out_free;
    assign s_ready = state_reg == S_IDLE;

    // next state and commands
    always_comb begin
        cmd        = '0;
        cmd.tail   = tail_reg;
        state_next = state_reg;
        tail_next  = tail_reg;
        big_next   = big_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (st.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    big_next   = 1'b0;
                    if (st.first_seen) begin
                        state_next = S_READ;
                    end else if (st.final_now) begin
                        state_next = S_LOAD;
                        tail_next  = lzwc_pkg::TAIL_CUR;
                    end
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                priority if (st.slot_empty) begin
                    cmd.insert = 1'b1;
                    state_next = S_LOAD;
                    tail_next  = lzwc_pkg::TAIL_MISS;
                end else if (st.slot_match) begin
                    cmd.hit    = 1'b1;
                    state_next = st.final_blk ? S_LOAD : S_IDLE;
                    tail_next  = lzwc_pkg::TAIL_CUR;
                end else if (st.probe_last) begin
                    state_next = S_LOAD;
                    tail_next  = lzwc_pkg::TAIL_MISS;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                if (st.dropped) begin
                    if (tail_reg == lzwc_pkg::TAIL_ZERO) begin
                        big_next = 1'b1;
                    end
                    state_next = adv_state;
                    tail_next  = adv_tail;
                end else begin
                    state_next = S_BYTE;
                end
            end
            S_BYTE: begin
                if (st.total_ge8) begin
                    cmd.emit = emit_ok;
                end else begin
                    cmd.pack_done = 1'b1;
                    state_next    = adv_state;
                    tail_next     = adv_tail;
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    cmd.finish  = 1'b1;
                    cmd.too_big = big_reg;
                    state_next  = st.epoch_max ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            tail_reg  <= lzwc_pkg::TAIL_MISS;
            big_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
            big_reg   <= big_next;
        end
    end

    // no transaction is taken during the table sweep
    `LZWC_ASSERT_NOW(a_no_accept_in_clear, state_reg == S_CLEAR, !cmd.accept)
    // a held byte is only displaced into a free output register
    `LZWC_ASSERT_NOW(a_hold_needs_room, cmd.emit && st.final_blk && st.hold_valid, st.out_free)
    // probing stops after a full pass over the table
    `LZWC_ASSERT_NOW(a_probe_bound, cmd.advance, !st.probe_last)
    // block end returns to idle or starts a sweep
    `LZWC_ASSERT_NEXT(a_finish_exit, cmd.finish, state_reg == S_IDLE || state_reg == S_CLEAR)

endmodule

@@ rtl/core/lzw_compressor_14bit.sv @@
// LZW compressor with fixed 14-bit codes: top level.
// Bytes of a block of block_length bytes enter one transaction at a time on s_*; packed
// code bytes leave on m_*, the last result of a block carrying out_last and too_big.
// The first byte of a block is only taken, unless it is also the last. Every other byte is
// taken and then probed in the dictionary, each probe being one read of the
// single-read-port hash table, then the compare. A code that is sent is loaded, its output
// bytes are emitted, and its leftover bits are kept for the next code; a dropped code is
// only loaded. The last byte of a block also packs the string, end and flush codes, and
// the closing transaction follows. Output back-pressure stalls byte emission.
// After reset, and after every 255th block, the table is swept clear entry by entry,
// during which no byte is taken; configuration writes are always taken. Write
// block_length only between blocks.
module lzw_compressor_14bit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_has_byte,
    output logic                       m_out_last,
    output logic                       m_too_big,
    input  logic                       cfg_wen,
    input  logic [lzwc_pkg::LEN_W-1:0] cfg_wdata
);

    lzwc_pkg::ctrl_cmd_t  cmd;
    lzwc_pkg::dp_status_t st;

    lzwc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    lzwc_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .s_data_byte (s_data_byte),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_has_byte  (m_has_byte),
        .m_out_last  (m_out_last),
        .m_too_big   (m_too_big)
    );

endmodule
